@@ src/hall_sensor_angle_speed_decoder_assert.svh @@
// Assertion macros for the hall sensor angle and speed decoder.
// Included by the top level; no other dependencies.
`ifndef HALL_SENSOR_ANGLE_SPEED_DECODER_ASSERT_SVH
`define HALL_SENSOR_ANGLE_SPEED_DECODER_ASSERT_SVH
`ifndef SYNTH
`define HSD_ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define HSD_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define HSD_ASSERT_IMPL(label, clk, rst_n, a, c)
`define HSD_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

@@ src/hsd_pkg.sv @@
// Shared types and constants for the hall sensor angle and speed decoder.
// No dependencies.
package hsd_pkg;
  localparam int AngleBits = 16;
  localparam logic [2:0] BadSector = 3'd7;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StBadObs  = 3'd1;
  localparam logic [2:0] StBadCode = 3'd2;
  localparam logic [2:0] StMissed  = 3'd3;
  localparam logic [2:0] StBadJump = 3'd4;

  localparam logic [2:0] CfgMap = 3'd0;

  // Flag bit positions.
  localparam int FState = 0;
  localparam int FDir   = 1;
  localparam int FAngle = 2;
  localparam int FSpeed = 3;
  localparam int FEdge  = 4;
  localparam int FTime  = 5;

  // Controller to datapath commands.
  typedef struct packed {
    logic decide;    // evaluate the latched item and update held state
    logic div_start; // start the speed division
    logic div_step;  // one quotient bit
    logic div_done;  // write the speed result
  } hsd_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic need_div;
    logic div_last;
  } hsd_sts_t;
endpackage

@@ src/hall_sensor_angle_speed_decoder.sv @@
// Top level of the hall sensor angle and speed decoder.
// Depends on hsd_pkg, hsd_ctrl, hsd_datapath and the assertion header.
//
//   port group | direction | transfer when
//   in_*       | input     | in_valid && in_ready
//   out_*      | output    | out_valid && out_ready
//   cfg_*      | input     | cfg_valid && cfg_ready (always ready)
//
// An item passes through the evaluate state, and the divide state when a speed is computed: the restoring
// divider produces one quotient bit per cycle over a 48-bit dividend.
// Reset is synchronous, active low, and restores register defaults.
// The result is held in registers until out_ready takes it.
`include "hall_sensor_angle_speed_decoder_assert.svh"
module hall_sensor_angle_speed_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_hall_code,
  input  logic               in_sample_present,
  input  logic [31:0]        in_capture_number,
  input  logic               in_timed_out,
  input  logic               in_interval_present,
  input  logic [31:0]        in_edge_interval_ticks,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic [2:0]         out_hall_code_out,
  output logic [2:0]         out_sector_out,
  output logic signed [1:0]  out_direction_out,
  output logic [15:0]        out_electrical_angle,
  output logic signed [31:0] out_electrical_speed,
  output logic [14:0]        out_span_out,
  output logic [31:0]        out_transition_total,
  output logic [5:0]         out_flag_bits,
  output logic [31:0]        out_missed_capture_total,
  output logic [31:0]        out_bad_transition_total,
  output logic [31:0]        out_bad_state_total
);
  hsd_pkg::hsd_cmd_t cmd;
  hsd_pkg::hsd_sts_t sts;

  assign cfg_ready = 1'b1;

  hsd_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .sts
  );

  hsd_datapath u_dp (
    .clk, .rst_n, .cfg_valid, .cfg_index, .cfg_data,
    .in_take(in_valid && in_ready),
    .in_hall_code, .in_sample_present, .in_capture_number, .in_timed_out,
    .in_interval_present, .in_edge_interval_ticks, .cmd, .sts,
    .out_status, .out_hall_code_out, .out_sector_out, .out_direction_out,
    .out_electrical_angle, .out_electrical_speed, .out_span_out,
    .out_transition_total, .out_flag_bits, .out_missed_capture_total,
    .out_bad_transition_total, .out_bad_state_total
  );

  `HSD_ASSERT_IMPL(a_no_in_while_out, clk, rst_n, out_valid, !in_ready)
  `HSD_ASSERT_NEXT(a_take_to_busy, clk, rst_n, in_valid && in_ready, !in_ready && !out_valid)
  `HSD_ASSERT_IMPL(a_status_range, clk, rst_n, out_valid, out_status <= 3'd4)
endmodule

@@ src/hsd_ctrl.sv @@
// Controller state machine of the hall decoder.
// Depends on hsd_pkg.
module hsd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output hsd_pkg::hsd_cmd_t cmd,
  input  hsd_pkg::hsd_sts_t sts
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.decide = 1'b1;
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          cmd.div_done = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule

@@ src/hsd_datapath.sv @@
// Datapath of the hall decoder: config registers, held state, restoring divider.
// Depends on hsd_pkg.
module hsd_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_take,
  input  logic [2:0]         in_hall_code,
  input  logic               in_sample_present,
  input  logic [31:0]        in_capture_number,
  input  logic               in_timed_out,
  input  logic               in_interval_present,
  input  logic [31:0]        in_edge_interval_ticks,
  input  hsd_pkg::hsd_cmd_t  cmd,
  output hsd_pkg::hsd_sts_t  sts,
  output logic [2:0]         out_status,
  output logic [2:0]         out_hall_code_out,
  output logic [2:0]         out_sector_out,
  output logic signed [1:0]  out_direction_out,
  output logic [15:0]        out_electrical_angle,
  output logic signed [31:0] out_electrical_speed,
  output logic [14:0]        out_span_out,
  output logic [31:0]        out_transition_total,
  output logic [5:0]         out_flag_bits,
  output logic [31:0]        out_missed_capture_total,
  output logic [31:0]        out_bad_transition_total,
  output logic [31:0]        out_bad_state_total
);
  localparam int AB = hsd_pkg::AngleBits;

  logic [23:0] map_r;
  logic [AB-1:0] edge_r [6];

  // Latched item.
  logic [2:0] code_r;
  logic present_r, to_r, hasiv_r;
  logic [31:0] cap_r, ticks_r;

  // Held state.
  logic [2:0] hcode_r, hsec_r, status_r;
  logic [1:0] hdir_r;
  logic [AB-1:0] hang_r;
  logic [31:0] hspd_r, htr_r, lastcap_r, miss_r, bjump_r, bcode_r;
  logic [AB:0] hspan_r;
  logic [5:0] hflags_r;
  logic seen_r;

  // Divider.
  logic [48:0] rem_r;       // partial remainder, fits divisor plus one bit
  logic [47:0] num_r;       // dividend shifting out
  logic [47:0] quo_r;
  logic [5:0] cnt_r;
  logic neg_r;

  function automatic logic [AB:0] span_f(input logic [AB-1:0] a, input logic [AB-1:0] b);
    logic [AB-1:0] d;
    d = b - a;
    span_f = (d == '0) ? {1'b1, {AB{1'b0}}} : {1'b0, d};
  endfunction

  logic [2:0] s, prev, nx_s, nx_p, s1;
  logic [AB:0] span_s, span_p;
  logic [31:0] delta;
  logic first, new_cap, to_chg, st_ok;
  logic [2:0] step;

  always_comb begin
    s = 3'(map_r >> (3 * code_r));
    prev = (hsec_r >= 3'd6) ? hsec_r - 3'd6 : hsec_r;
    nx_s = (s >= 3'd5) ? 3'd0 : s + 3'd1;
    nx_p = (prev == 3'd5) ? 3'd0 : prev + 3'd1;
    s1 = (s < 3'd6) ? s : 3'd0;
    span_s = span_f(edge_r[s1], edge_r[nx_s]);
    span_p = span_f(edge_r[prev], edge_r[nx_p]);
    delta = cap_r - lastcap_r;
    first = !seen_r;
    new_cap = !first && delta != 0;
    to_chg = first || (to_r != hflags_r[hsd_pkg::FTime]);
    st_ok = hflags_r[hsd_pkg::FState];
    step = (s1 >= prev) ? s1 - prev : s1 + 3'd6 - prev;
    sts.need_div = !(to_r && hasiv_r) && present_r && !(first || !st_ok) && s < 3'd6
                   && new_cap && delta == 32'd1 && hasiv_r && ticks_r != 0
                   && (step == 3'd1 || step == 3'd5);
    sts.div_last = (cnt_r == 6'd47);
  end

  logic [48:0] trial;
  assign trial = {rem_r[47:0], num_r[47]} - {17'd0, ticks_r};

  always_ff @(posedge clk) begin
    if (in_take) begin
      code_r <= in_hall_code; present_r <= in_sample_present; cap_r <= in_capture_number;
      to_r <= in_timed_out; hasiv_r <= in_interval_present; ticks_r <= in_edge_interval_ticks;
    end
    if (cmd.div_start) begin
      rem_r <= '0;
      num_r <= {15'd0, span_p, {(32 - AB){1'b0}}};
      cnt_r <= '0;
      neg_r <= (step == 3'd5);
    end else if (cmd.div_step) begin
      if (!trial[48]) begin
        rem_r <= trial; quo_r <= {quo_r[46:0], 1'b1};
      end else begin
        rem_r <= {rem_r[47:0], num_r[47]}; quo_r <= {quo_r[46:0], 1'b0};
      end
      num_r <= {num_r[46:0], 1'b0};
      cnt_r <= cnt_r + 6'd1;
    end
  end

  logic [47:0] q_fin;
  logic [31:0] mag;
  assign q_fin = {quo_r[46:0], !trial[48]};
  assign mag = (q_fin > 48'h7FFFFFFF) ? 32'h7FFFFFFF : q_fin[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r <= 24'hFFFFFF;
      edge_r[0] <= AB'(0);     edge_r[1] <= AB'(10923); edge_r[2] <= AB'(21845);
      edge_r[3] <= AB'(32768); edge_r[4] <= AB'(43691); edge_r[5] <= AB'(54613);
      hcode_r <= '0; hsec_r <= hsd_pkg::BadSector; hdir_r <= '0; hang_r <= '0;
      hspd_r <= '0; hspan_r <= '0; htr_r <= '0; hflags_r <= '0; seen_r <= 1'b0;
      lastcap_r <= '0; miss_r <= '0; bjump_r <= '0; bcode_r <= '0;
      status_r <= hsd_pkg::StOk;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == hsd_pkg::CfgMap) map_r <= cfg_data;
        else if (cfg_index <= 3'd6) edge_r[cfg_index - 3'd1] <= cfg_data[AB-1:0];
      end
      if (cmd.div_done) begin
        hspd_r <= neg_r ? 32'd0 - mag : mag;
        hflags_r[hsd_pkg::FSpeed] <= 1'b1;
      end
      if (cmd.decide) begin
        if (to_r && hasiv_r) begin
          status_r <= hsd_pkg::StBadObs;
        end else if (!present_r) begin
          hcode_r <= code_r; hsec_r <= hsd_pkg::BadSector; hdir_r <= '0; hang_r <= '0;
          hspd_r <= '0; hspan_r <= '0; hflags_r <= {to_r, 5'd0};
          seen_r <= 1'b1; lastcap_r <= cap_r; status_r <= hsd_pkg::StBadObs;
        end else if (!first && !new_cap && !to_chg) begin
          status_r <= st_ok ? hsd_pkg::StOk : hsd_pkg::StBadCode;
        end else if (new_cap && hasiv_r && ticks_r == 0) begin
          status_r <= hsd_pkg::StBadObs;
        end else begin
          seen_r <= 1'b1; lastcap_r <= cap_r;
          if (s >= 3'd6) begin
            hcode_r <= code_r; hsec_r <= hsd_pkg::BadSector; hdir_r <= '0; hang_r <= '0;
            hspd_r <= '0; hspan_r <= '0; hflags_r <= {to_r, 5'd0};
            bcode_r <= bcode_r + 32'd1; status_r <= hsd_pkg::StBadCode;
          end else if (first || !st_ok || (new_cap && (delta != 32'd1 ||
                       !(step == 3'd1 || step == 3'd5)))) begin
            // Resynchronize to the sector centre.
            hcode_r <= code_r; hsec_r <= s; hdir_r <= '0; hspd_r <= '0;
            hang_r <= edge_r[s1] + span_s[AB:1]; hspan_r <= span_s;
            if (first || !st_ok) begin
              hflags_r <= {to_r, 1'b0, to_r, 1'b1, 1'b0, 1'b1};
              status_r <= hsd_pkg::StOk;
            end else begin
              hflags_r <= 6'b000101;
              if (delta != 32'd1) begin
                miss_r <= miss_r + delta - 32'd1; status_r <= hsd_pkg::StMissed;
              end else begin
                bjump_r <= bjump_r + 32'd1; status_r <= hsd_pkg::StBadJump;
              end
            end
          end else if (!new_cap) begin
            hspd_r <= '0;
            hflags_r[hsd_pkg::FTime] <= to_r; hflags_r[hsd_pkg::FSpeed] <= to_r;
            status_r <= hsd_pkg::StOk;
          end else begin
            hcode_r <= code_r; hsec_r <= s;
            hdir_r <= (step == 3'd1) ? 2'sb01 : 2'sb11;
            hang_r <= (step == 3'd1) ? edge_r[s1] : edge_r[nx_s];
            hspd_r <= '0; hspan_r <= span_s; hflags_r <= 6'b010111;
            htr_r <= htr_r + 32'd1; status_r <= hsd_pkg::StOk;
          end
        end
      end
    end
  end

  assign out_status = status_r;
  assign out_hall_code_out = hcode_r;
  assign out_sector_out = hsec_r;
  assign out_direction_out = hdir_r;
  assign out_electrical_angle = 16'(hang_r);
  assign out_electrical_speed = hspd_r;
  assign out_span_out = 15'(hspan_r);
  assign out_transition_total = htr_r;
  assign out_flag_bits = hflags_r;
  assign out_missed_capture_total = miss_r;
  assign out_bad_transition_total = bjump_r;
  assign out_bad_state_total = bcode_r;
endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the hall sensor angle and speed decoder.
// Depends on hsd_pkg and the hall_sensor_angle_speed_decoder top level.
module testbench;
  import hsd_pkg::*;

  typedef struct packed {
    logic [2:0]  code;
    logic        present;
    logic [31:0] cap;
    logic        to;
    logic        has_iv;
    logic [31:0] ticks;
  } hall_obs_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  code;
    logic [2:0]  sector;
    logic [1:0]  dir;
    logic [15:0] angle;
    logic [31:0] speed;
    logic [14:0] span;
    logic [31:0] trans;
    logic [5:0]  flags;
    logic [31:0] missed;
    logic [31:0] bad_jump;
    logic [31:0] bad_code;
  } hall_est_t;

  localparam logic [2:0] CfgEdge0 = 3'd1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = CfgMap;
  logic [23:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  hall_obs_t drv = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  hall_est_t got;

  hall_obs_t pending_obs[$];
  hall_est_t expected_est[$];
  bit failed = 1'b0;

  // Predictor state.
  logic [23:0] p_map;
  logic [15:0] p_edge[6];
  logic [2:0]  h_code, h_sector;
  logic [1:0]  h_dir;
  logic [15:0] h_angle;
  logic [31:0] h_speed;
  logic [16:0] h_span;
  logic [31:0] h_trans, h_missed, h_jump, h_badcode, h_lastcap;
  logic [5:0]  h_flags;
  bit          h_seen;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hall_sensor_angle_speed_decoder dut (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready,
    .in_hall_code(drv.code), .in_sample_present(drv.present),
    .in_capture_number(drv.cap), .in_timed_out(drv.to),
    .in_interval_present(drv.has_iv), .in_edge_interval_ticks(drv.ticks),
    .out_valid, .out_ready,
    .out_status(got.status), .out_hall_code_out(got.code),
    .out_sector_out(got.sector), .out_direction_out(got.dir),
    .out_electrical_angle(got.angle), .out_electrical_speed(got.speed),
    .out_span_out(got.span), .out_transition_total(got.trans),
    .out_flag_bits(got.flags), .out_missed_capture_total(got.missed),
    .out_bad_transition_total(got.bad_jump), .out_bad_state_total(got.bad_code)
  );

  function automatic logic [16:0] sector_span(int s);
    logic [15:0] d;
    d = p_edge[(s + 1) % 6] - p_edge[s];
    return (d == 16'd0) ? 17'h10000 : {1'b0, d};
  endfunction

  function automatic void clear_held(logic [2:0] code, logic to);
    h_code = code; h_sector = BadSector; h_dir = 2'd0; h_angle = '0;
    h_speed = '0; h_span = '0;
    h_flags = '0;
    h_flags[FTime] = to;
  endfunction

  function automatic void center_on(logic [2:0] code, int s, logic to);
    h_span = sector_span(s);
    h_code = code; h_sector = s[2:0]; h_dir = 2'd0;
    h_angle = p_edge[s] + h_span[16:1];
    h_speed = '0;
    h_flags = '0;
    h_flags[FState] = 1'b1; h_flags[FAngle] = 1'b1;
    h_flags[FSpeed] = to; h_flags[FTime] = to;
  endfunction

  function automatic hall_est_t held_result(logic [2:0] st);
    return '{st, h_code, h_sector, h_dir, h_angle, h_speed, h_span[14:0],
             h_trans, h_flags, h_missed, h_jump, h_badcode};
  endfunction

  function automatic hall_est_t decode_obs(hall_obs_t o);
    bit first, new_cap, to_chg, ok;
    logic [31:0] delta;
    int s, prev, stp, ei;
    logic [47:0] q;
    if (o.to && o.has_iv) return held_result(StBadObs);
    if (!o.present) begin
      clear_held(o.code, o.to);
      h_seen = 1'b1; h_lastcap = o.cap;
      return held_result(StBadObs);
    end
    first = !h_seen;
    delta = o.cap - h_lastcap;
    new_cap = !first && delta != 0;
    to_chg = first || (o.to != h_flags[FTime]);
    ok = h_flags[FState];
    if (!first && !new_cap && !to_chg) return held_result(ok ? StOk : StBadCode);
    if (new_cap && o.has_iv && o.ticks == 0) return held_result(StBadObs);
    h_seen = 1'b1; h_lastcap = o.cap;
    s = (p_map >> (3 * o.code)) & 7;
    if (s >= 6) begin
      clear_held(o.code, o.to);
      h_badcode++;
      return held_result(StBadCode);
    end
    if (first || !ok) begin
      center_on(o.code, s, o.to);
      return held_result(StOk);
    end
    if (!new_cap) begin
      h_speed = '0;
      h_flags[FTime] = o.to; h_flags[FSpeed] = o.to;
      return held_result(StOk);
    end
    if (delta != 1) begin
      h_missed += delta - 1;
      center_on(o.code, s, 1'b0);
      return held_result(StMissed);
    end
    prev = h_sector % 6;
    stp = (s + 6 - prev) % 6;
    if (stp != 1 && stp != 5) begin
      h_jump++;
      center_on(o.code, s, 1'b0);
      return held_result(StBadJump);
    end
    ei = (stp == 1) ? s : (s + 1) % 6;
    h_code = o.code; h_sector = s[2:0];
    h_dir = (stp == 1) ? 2'b01 : 2'b11;
    h_angle = p_edge[ei];
    h_speed = '0;
    h_span = sector_span(s);
    h_flags = 6'b010111;
    h_trans++;
    if (o.has_iv) begin
      q = {15'd0, sector_span(prev), 16'd0} / {16'd0, o.ticks};
      if (q > 48'h7FFFFFFF) q = 48'h7FFFFFFF;
      h_speed = (stp == 1) ? q[31:0] : 32'd0 - q[31:0];
      h_flags[FSpeed] = 1'b1;
    end
    return held_result(StOk);
  endfunction

  // Sender: bursts of transfers separated by random gaps.
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_est.push_back(decode_obs(drv));
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_obs.size() > 0) begin
          drv <= pending_obs.pop_front();
          in_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stalls on a pattern that changes from time to time.
  logic [7:0] stall_pat = 8'hff;
  int pat_pos = 0;
  always @(posedge clk) begin
    hall_est_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_est.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          failed = 1'b1;
        end else begin
          e = expected_est.pop_front();
          if (e !== got) begin
            $display("%0t: mismatch expected %h actual %h", $time, e, got);
            if (e.status !== got.status)
              $display("%0t:   status expected %0d actual %0d", $time, e.status, got.status);
            if (e.speed !== got.speed)
              $display("%0t:   speed expected %h actual %h", $time, e.speed, got.speed);
            if (e.flags !== got.flags)
              $display("%0t:   flags expected %b actual %b", $time, e.flags, got.flags);
            failed = 1'b1;
          end
        end
      end
      if (pat_pos == 7) stall_pat <= ($urandom_range(0, 2) == 0) ? 8'hff : 8'($urandom);
      pat_pos <= (pat_pos + 1) % 8;
      out_ready <= stall_pat[pat_pos];
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CfgMap) p_map = val;
    else p_edge[idx - CfgEdge0] = val[15:0];
  endtask

  task automatic drain();
    while (pending_obs.size() > 0 || in_valid || expected_est.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic hall_obs_t obs(logic [2:0] c, logic p, logic [31:0] cap,
                                    logic to, logic iv, logic [31:0] t);
    return '{c, p, cap, to, iv, t};
  endfunction

  // Walks a sequence mostly of adjacent steps in a standard 120-degree code order.
  task automatic queue_run(int n, ref logic [31:0] cap);
    logic [2:0] fwd[6] = '{3'd1, 3'd3, 3'd2, 3'd6, 3'd4, 3'd5};
    int pos, r;
    hall_obs_t o;
    pos = $urandom_range(0, 5);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) pos = (pos + 1) % 6;
      else if (r < 75) pos = (pos + 5) % 6;
      o = obs(fwd[pos], 1'b1, cap + 1, 1'b0, $urandom_range(0, 5) != 0, 32'd0);
      o.ticks = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 4000);
      if (r >= 75 && r < 80) o.cap = cap + $urandom_range(2, 5);
      else if (r >= 80 && r < 84) o.cap = cap;
      else if (r >= 84 && r < 87) o.code = 3'($urandom);
      else if (r >= 87 && r < 89) o.present = 1'b0;
      else if (r >= 89 && r < 92) o.to = 1'b1;
      else if (r >= 92 && r < 94) o.ticks = 32'd0;
      else if (r >= 94 && r < 96) o = hall_obs_t'({$urandom, $urandom, $urandom});
      else if (r >= 96) o.cap = $urandom;
      cap = o.cap;
      pending_obs.push_back(o);
    end
  endtask

  initial begin
    logic [31:0] cap;
    p_map = 24'hFFFFFF;
    p_edge = '{16'd0, 16'd10923, 16'd21845, 16'd32768, 16'd43691, 16'd54613};
    h_code = '0; h_sector = BadSector; h_dir = '0; h_angle = '0; h_speed = '0;
    h_span = '0; h_trans = '0; h_flags = '0; h_seen = 1'b0; h_lastcap = '0;
    h_missed = '0; h_jump = '0; h_badcode = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: all-invalid map at reset, then a real map.
    pending_obs.push_back(obs(3'd1, 1'b1, 32'd5, 1'b0, 1'b0, 32'd0));
    pending_obs.push_back(obs(3'd2, 1'b0, 32'd6, 1'b1, 1'b0, 32'd0));
    drain();
    // Codes 1,3,2,4,6,5 map to sectors 0..5; codes 0 and 7 invalid (6 and 7).
    write_reg(CfgMap, {3'd7, 3'd4, 3'd5, 3'd3, 3'd1, 3'd2, 3'd0, 3'd6});
    pending_obs.push_back(obs(3'd1, 1'b1, 32'd7, 1'b0, 1'b0, 32'd0));
    pending_obs.push_back(obs(3'd3, 1'b1, 32'd8, 1'b0, 1'b1, 32'd1));
    pending_obs.push_back(obs(3'd2, 1'b1, 32'd9, 1'b0, 1'b1, 32'hFFFFFFFF));
    pending_obs.push_back(obs(3'd3, 1'b1, 32'd10, 1'b0, 1'b1, 32'd1000));
    pending_obs.push_back(obs(3'd3, 1'b1, 32'd10, 1'b0, 1'b0, 32'd0));
    pending_obs.push_back(obs(3'd3, 1'b1, 32'd10, 1'b1, 1'b0, 32'd0));
    pending_obs.push_back(obs(3'd3, 1'b1, 32'd10, 1'b1, 1'b1, 32'd9));
    pending_obs.push_back(obs(3'd2, 1'b1, 32'd11, 1'b0, 1'b1, 32'd0));
    pending_obs.push_back(obs(3'd6, 1'b1, 32'd15, 1'b0, 1'b1, 32'd50));
    pending_obs.push_back(obs(3'd5, 1'b1, 32'd16, 1'b0, 1'b0, 32'd0));
    pending_obs.push_back(obs(3'd6, 1'b1, 32'd17, 1'b0, 1'b0, 32'd0));
    pending_obs.push_back(obs(3'd0, 1'b1, 32'd18, 1'b0, 1'b0, 32'd0));
    pending_obs.push_back(obs(3'd7, 1'b1, 32'd18, 1'b1, 1'b0, 32'd0));
    pending_obs.push_back(obs(3'd1, 1'b1, 32'hFFFFFFFF, 1'b0, 1'b0, 32'd0));
    pending_obs.push_back(obs(3'd5, 1'b1, 32'd0, 1'b0, 1'b1, 32'd3));
    drain();

    // Random phases over several geometries, extremes among them.
    cap = h_lastcap;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        1: for (int k = 0; k < 6; k++) write_reg(3'(CfgEdge0 + k), 24'hFFFFFF);
        2: for (int k = 0; k < 6; k++)
          write_reg(3'(CfgEdge0 + k), 24'(k * 16'h2AAB + 16'hF000));
        3: begin
          write_reg(CfgMap, 24'h000000);
          for (int k = 0; k < 6; k++) write_reg(3'(CfgEdge0 + k), 24'($urandom));
        end
        4: write_reg(CfgMap, {3'd6, 3'd2, 3'd1, 3'd3, 3'd5, 3'd4, 3'd0, 3'd7});
        5: for (int k = 0; k < 6; k++) write_reg(3'(CfgEdge0 + k), 24'(k));
        6: begin
          write_reg(CfgMap, 24'($urandom));
          for (int k = 0; k < 6; k++) write_reg(3'(CfgEdge0 + k), 24'($urandom));
        end
        7: write_reg(CfgMap, {3'd7, 3'd4, 3'd5, 3'd3, 3'd1, 3'd2, 3'd0, 3'd6});
        default: ;
      endcase
      queue_run(130, cap);
      drain();
    end

    if (!failed) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

  initial begin
    #5000000;
    $display("testbench: FAIL");
    $finish;
  end
endmodule
